// ----- src/mqed_pkg.sv -----
package mqed_pkg;

  // Sizing of the queue set.
  localparam int NUM_QUEUES  = 32;
  localparam int QUEUE_DEPTH = 8;
  localparam int TAG_WIDTH   = 16;

  // Derived widths. Queue depth is a power of two, so slot pointers wrap
  // naturally and a store address is the queue number above the slot.
  localparam int QIDX_W  = $clog2(NUM_QUEUES);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = QIDX_W + PTR_W;
  localparam int STORE_N = NUM_QUEUES * QUEUE_DEPTH;
  localparam int TOT_W   = $clog2(STORE_N + 1);

  // Configuration register widths and indexes.
  localparam int QUSE_W = 6;
  localparam int CAP_W  = 4;
  localparam int CFG_W  = 6;
  localparam logic REG_QUEUES_IN_USE  = 1'b0;
  localparam logic REG_CAPACITY_LIMIT = 1'b1;
  localparam logic [QUSE_W-1:0] QUEUES_IN_USE_RESET  = 6'd20;
  localparam logic [CAP_W-1:0]  CAPACITY_LIMIT_RESET = 4'd5;

  // Operation codes.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_TAKEN   = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  typedef struct packed {
    logic                 op;
    logic [4:0]           queue_index;
    logic                 urgent;
    logic [TAG_WIDTH-1:0] entry_tag;
  } item_word_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [TAG_WIDTH-1:0] taken_tag;
    logic                 taken_urgent;
    logic [3:0]           queue_count;
    logic                 any_waiting;
  } result_word_t;

  // One stored entry: urgent mark above the tag.
  typedef struct packed {
    logic                 urgent;
    logic [TAG_WIDTH-1:0] tag;
  } entry_t;

  // Per-queue bookkeeping: slot of the head and number of entries.
  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [CNT_W-1:0] count;
  } meta_t;

endpackage

// ----- src/multi_queue_expedite_deque_core.sv -----
// Bounded double-ended queue manager. Holds up to 32 queues of up to 8
// entries each (tag plus urgent mark) in two synchronous-read memories:
// a 32-entry queue bookkeeping memory (head slot and count, reads as zero
// until first written, tracked by per-queue valid flops) and a 256-entry
// entry store. Items are handled one at a time. For an add, a rejected add, a
// take from an empty queue or an invalid index, the bookkeeping read happens
// at acceptance and the update and result load follow in the bookkeeping
// state. A successful take goes on from the bookkeeping state to a data state
// and loads its result there, since the head slot read from bookkeeping
// addresses the entry store read. The next word is accepted in the cycle
// after the result loads. A stalled result register holds the item back until
// the result can be loaded. Configuration is taken on any cycle with cfg_write.
module multi_queue_expedite_deque_core import mqed_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  item_word_t   item,
  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result,
  input  logic         cfg_write,
  input  logic         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_META = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;

  logic [1:0]        state;
  item_word_t        cur;
  logic [QUSE_W-1:0] queues_in_use;
  logic [CAP_W-1:0]  capacity_limit;
  logic [TOT_W-1:0]  total_entries;
  logic [TOT_W-1:0]  total_next;

  meta_t             meta_mem [NUM_QUEUES];
  meta_t             meta_rd;
  logic [NUM_QUEUES-1:0] meta_valid;
  entry_t            entry_mem [STORE_N];
  entry_t            entry_rd;

  logic [QIDX_W-1:0] meta_raddr;
  logic [ADDR_W-1:0] entry_raddr;
  logic [ADDR_W-1:0] entry_waddr;
  meta_t             meta_cur;
  meta_t             meta_new;
  logic [QUSE_W-1:0] active_eff;
  logic [CAP_W-1:0]  limit_eff;
  logic              invalid;
  logic              full;
  logic              empty;
  logic              add_ok;
  logic              take_ok;
  logic [PTR_W-1:0]  add_slot;
  logic              out_free;
  logic              commit;
  result_word_t      result_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      queues_in_use  <= QUEUES_IN_USE_RESET;
      capacity_limit <= CAPACITY_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_QUEUES_IN_USE:  queues_in_use  <= cfg_data[QUSE_W-1:0];
        REG_CAPACITY_LIMIT: capacity_limit <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Bookkeeping is read every cycle; the address holds while an item waits.
  assign meta_raddr  = (state == S_IDLE) ? item.queue_index[QIDX_W-1:0]
                                         : cur.queue_index[QIDX_W-1:0];
  assign meta_cur    = meta_valid[cur.queue_index[QIDX_W-1:0]] ? meta_rd : '0;
  assign entry_raddr = {cur.queue_index[QIDX_W-1:0], meta_cur.head};

  // Effective limits after saturation.
  assign active_eff = (queues_in_use > QUSE_W'(NUM_QUEUES)) ? QUSE_W'(NUM_QUEUES)
                                                            : queues_in_use;
  assign limit_eff  = (capacity_limit > CAP_W'(QUEUE_DEPTH)) ? CAP_W'(QUEUE_DEPTH)
                                                             : capacity_limit;

  // Decision for the item in hand.
  assign invalid  = QUSE_W'(cur.queue_index) >= active_eff;
  assign full     = CAP_W'(meta_cur.count) >= limit_eff;
  assign empty    = (meta_cur.count == '0);
  assign add_ok   = !invalid && (cur.op == OP_ADD) && !full;
  assign take_ok  = !invalid && (cur.op == OP_TAKE) && !empty;
  assign add_slot = cur.urgent ? meta_cur.head - PTR_W'(1)
                               : meta_cur.head + meta_cur.count[PTR_W-1:0];
  assign entry_waddr = {cur.queue_index[QIDX_W-1:0], add_slot};

  // New bookkeeping for a successful add or take.
  always_comb begin
    meta_new = meta_cur;
    if (add_ok) begin
      meta_new.count = meta_cur.count + CNT_W'(1);
      if (cur.urgent) begin
        meta_new.head = add_slot;
      end
    end else if (take_ok) begin
      meta_new.count = meta_cur.count - CNT_W'(1);
      meta_new.head  = meta_cur.head + PTR_W'(1);
    end
  end

  always_comb begin
    total_next = total_entries;
    if (add_ok) begin
      total_next = total_entries + TOT_W'(1);
    end else if (take_ok) begin
      total_next = total_entries - TOT_W'(1);
    end
  end

  // Result word.
  always_comb begin
    result_next              = '0;
    result_next.any_waiting  = (total_next != '0);
    if (invalid) begin
      result_next.status = ST_INVALID;
    end else if (cur.op == OP_ADD) begin
      result_next.status      = full ? ST_FULL : ST_ADDED;
      result_next.queue_count = 4'(meta_new.count);
    end else if (empty) begin
      result_next.status = ST_EMPTY;
    end else begin
      result_next.status       = ST_TAKEN;
      result_next.queue_count  = 4'(meta_new.count);
      result_next.taken_tag    = entry_rd.tag;
      result_next.taken_urgent = entry_rd.urgent;
    end
  end

  // An item finishes once the result register can take its word.
  assign out_free   = !result_valid || !result_stall;
  assign commit     = out_free && (((state == S_META) && !take_ok) || (state == S_DATA));
  assign item_stall = (state != S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_META;
          end
        end
        S_META: begin
          if (take_ok) begin
            state <= S_DATA;
          end else if (commit) begin
            state <= S_IDLE;
          end
        end
        S_DATA: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      cur <= item;
    end
  end

  // Bookkeeping memory with valid flops standing in for its reset.
  always_ff @(posedge clk) begin
    meta_rd <= meta_mem[meta_raddr];
    if (commit && (add_ok || take_ok)) begin
      meta_mem[cur.queue_index[QIDX_W-1:0]] <= meta_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_valid <= '0;
    end else if (commit && (add_ok || take_ok)) begin
      meta_valid[cur.queue_index[QIDX_W-1:0]] <= 1'b1;
    end
  end

  // Entry store.
  always_ff @(posedge clk) begin
    entry_rd <= entry_mem[entry_raddr];
    if (commit && add_ok) begin
      entry_mem[entry_waddr] <= '{urgent: cur.urgent, tag: cur.entry_tag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_entries <= '0;
    end else if (commit) begin
      total_entries <= total_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result <= result_next;
    end
  end

  // The store can never hold more entries than it has slots.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total_entries <= TOT_W'(STORE_N))
    else $error("entry total exceeds store size");

  // A take result is only produced after the entry store read.
  a_taken_after_read: assert property (@(posedge clk) disable iff (rst)
    commit && (result_next.status == ST_TAKEN) |-> state == S_DATA)
    else $error("take finished without entry read");

  // A successful take lowers the running total by one.
  a_take_total: assert property (@(posedge clk) disable iff (rst)
    commit && take_ok |=> total_entries == $past(total_entries) - TOT_W'(1))
    else $error("take did not lower total");

  // Nothing is finished while the sequencer is idle.
  a_idle_no_commit: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !commit)
    else $error("commit while idle");

endmodule

// ----- dv/multi_queue_expedite_deque_core_test.sv -----
module multi_queue_expedite_deque_core_test;
  import mqed_pkg::*;

  // Clock, reset and block ports.
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         item_valid = 1'b0;
  logic         item_stall;
  item_word_t   item = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_word_t result;
  logic         cfg_write = 1'b0;
  logic         cfg_index = REG_QUEUES_IN_USE;
  logic [CFG_W-1:0] cfg_data = '0;

  multi_queue_expedite_deque_core DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Words waiting to be sent and results predicted for accepted words.
  item_word_t   pending_items[$];
  result_word_t expected_results[$];

  // Shadow copy of the queue set and its configuration.
  entry_t            shadow_store[NUM_QUEUES][QUEUE_DEPTH];
  logic [PTR_W-1:0]  shadow_head[NUM_QUEUES];
  logic [3:0]        shadow_count[NUM_QUEUES];
  int                shadow_total;
  logic [QUSE_W-1:0] shadow_queues_in_use;
  logic [CAP_W-1:0]  shadow_capacity;

  // Idle rates for each side, in percent.
  int send_idle_pct = 10;
  int recv_idle_pct = 49;

  int mismatches;
  int items_accepted;
  int results_seen;
  int entries_taken;
  int settings_used;
  result_word_t want_word;

  // Phase settings: queues in use and capacity limit, extremes included.
  int phase_queues[9] = '{32, 1, 63, 0, 33, 7, 32, 12, 20};
  int phase_cap[9]    = '{8, 1, 15, 3, 9, 0, 8, 2, 5};

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // Work out the result of one word and update the shadow state.
  function automatic result_word_t predict_deque(item_word_t w);
    result_word_t r;
    int active;
    int limit;
    logic [3:0] cnt;
    logic [PTR_W-1:0] slot;
    entry_t e;
    r = '0;
    active = (shadow_queues_in_use > NUM_QUEUES) ? NUM_QUEUES : int'(shadow_queues_in_use);
    limit = (shadow_capacity > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(shadow_capacity);
    if (int'(w.queue_index) >= active) begin
      r.status = ST_INVALID;
    end else begin
      cnt = shadow_count[w.queue_index];
      if (w.op == OP_ADD) begin
        if (int'(cnt) >= limit) begin
          r.status = ST_FULL;
        end else begin
          // Urgent entries go in front of the head, regular ones after the tail.
          if (w.urgent) begin
            slot = shadow_head[w.queue_index] - PTR_W'(1);
            shadow_head[w.queue_index] = slot;
          end else begin
            slot = shadow_head[w.queue_index] + cnt[PTR_W-1:0];
          end
          e.urgent = w.urgent;
          e.tag = w.entry_tag;
          shadow_store[w.queue_index][slot] = e;
          cnt = cnt + 4'(1);
          shadow_total++;
          r.status = ST_ADDED;
        end
      end else if (cnt == 0) begin
        r.status = ST_EMPTY;
      end else begin
        e = shadow_store[w.queue_index][shadow_head[w.queue_index]];
        r.taken_tag = e.tag;
        r.taken_urgent = e.urgent;
        shadow_head[w.queue_index] = shadow_head[w.queue_index] + PTR_W'(1);
        cnt = cnt - 4'(1);
        shadow_total--;
        r.status = ST_TAKEN;
      end
      shadow_count[w.queue_index] = cnt;
      r.queue_count = cnt;
    end
    r.any_waiting = (shadow_total != 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s is %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_word(logic op, int q, logic urg, int tag);
    item_word_t w;
    w.op = op;
    w.queue_index = q[4:0];
    w.urgent = urg;
    w.entry_tag = tag[TAG_WIDTH-1:0];
    pending_items.insert(pending_items.size(), w);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_reg(logic idx, int value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_QUEUES_IN_USE) shadow_queues_in_use = value[QUSE_W-1:0];
    else shadow_capacity = value[CAP_W-1:0];
    @(negedge clk);
  endtask

  // Wait until every word has been sent and every result has come back.
  task automatic drain();
    @(negedge clk);
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Driver: predict each accepted word, then present the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        expected_results.insert(expected_results.size(), predict_deque(item));
        items_accepted++;
      end
      if (!item_valid || !item_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= pending_items[0];
          pending_items.delete(0);
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", int'(result.status), 0);
        end else begin
          want_word = expected_results[0];
          expected_results.delete(0);
          if (result.status == ST_TAKEN) entries_taken++;
          if (result.status !== want_word.status)
            report_mismatch("status", int'(result.status), int'(want_word.status));
          if (result.taken_tag !== want_word.taken_tag)
            report_mismatch("taken_tag", int'(result.taken_tag),
                            int'(want_word.taken_tag));
          if (result.taken_urgent !== want_word.taken_urgent)
            report_mismatch("taken_urgent", int'(result.taken_urgent),
                            int'(want_word.taken_urgent));
          if (result.queue_count !== want_word.queue_count)
            report_mismatch("queue_count", int'(result.queue_count),
                            int'(want_word.queue_count));
          if (result.any_waiting !== want_word.any_waiting)
            report_mismatch("any_waiting", int'(result.any_waiting),
                            int'(want_word.any_waiting));
        end
      end
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Stimulus sequence.
  initial begin
    int active;
    int r;
    int q;
    int add_pct;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      shadow_head[i] = '0;
      shadow_count[i] = '0;
    end
    shadow_total = 0;
    shadow_queues_in_use = QUEUES_IN_USE_RESET;
    shadow_capacity = CAPACITY_LIMIT_RESET;
    mismatches = 0;
    items_accepted = 0;
    results_seen = 0;
    entries_taken = 0;
    settings_used = 1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset settings: empty take, fill to the limit with
    // mixed urgent and regular entries, reject when full, drain in order.
    queue_word(OP_TAKE, 0, 1'b0, 0);
    queue_word(OP_ADD, 0, 1'b0, 16'h0000);
    queue_word(OP_ADD, 0, 1'b1, 16'hFFFF);
    queue_word(OP_ADD, 0, 1'b0, 16'h1234);
    queue_word(OP_ADD, 0, 1'b1, 16'hABCD);
    queue_word(OP_ADD, 0, 1'b0, 16'h5555);
    queue_word(OP_ADD, 0, 1'b1, 16'h7777);
    repeat (5) queue_word(OP_TAKE, 0, 1'b0, 0);
    queue_word(OP_TAKE, 0, 1'b0, 0);
    // Highest valid queue, then indices beyond the queues in use.
    queue_word(OP_ADD, 19, 1'b1, 16'hFFFF);
    queue_word(OP_ADD, 20, 1'b1, 16'hFFFF);
    queue_word(OP_TAKE, 31, 1'b1, 16'hFFFF);
    queue_word(OP_ADD, 31, 1'b0, 16'h8001);
    queue_word(OP_TAKE, 19, 1'b0, 0);
    // An urgent add to an empty queue wraps the head slot backward.
    queue_word(OP_ADD, 5, 1'b1, 16'h00FF);
    queue_word(OP_ADD, 5, 1'b0, 16'hFF00);
    queue_word(OP_TAKE, 5, 1'b0, 0);
    queue_word(OP_TAKE, 5, 1'b0, 0);
    drain();

    // Random phases: settings change between phases, state carries over, so a
    // lowered limit meets queues that already hold more than it allows.
    for (int p = 0; p < 9; p++) begin
      write_reg(REG_QUEUES_IN_USE, phase_queues[p]);
      write_reg(REG_CAPACITY_LIMIT, phase_cap[p]);
      settings_used++;
      case (p / 3)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      active = (shadow_queues_in_use > NUM_QUEUES) ? NUM_QUEUES
                                                   : int'(shadow_queues_in_use);
      add_pct = (p % 2 == 0) ? 65 : 40;
      for (int n = 0; n < 84; n++) begin
        // Mostly a few hot valid queues so they fill and wrap; some noise.
        r = $urandom_range(99);
        if (active == 0 || r >= 85) q = $urandom_range(31);
        else if (r < 60) q = $urandom_range(((active < 4) ? active : 4) - 1);
        else q = $urandom_range(active - 1);
        queue_word(($urandom_range(99) < add_pct) ? OP_ADD : OP_TAKE, q,
                   1'($urandom_range(1)), $urandom_range(16'hFFFF));
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());
    $display("Run covered %0d words and %0d results over %0d register settings.",
             items_accepted, results_seen, settings_used);
    $display("Entries taken back out of the queues: %0d; mismatches: %0d.",
             entries_taken, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/mqed_pkg.sv
src/multi_queue_expedite_deque_core.sv
dv/multi_queue_expedite_deque_core_test.sv
